/* hw/rtl/pibf_pkg.sv */
// Shared types, constants and helper functions for the flood/blacklist filter.
package pibf_pkg;

    localparam int IP_ENTRIES = 64;
    localparam int IDX_W      = $clog2(IP_ENTRIES);
    localparam int PORT_DEPTH = 65536;
    localparam int PORT_AW    = 16;

    localparam logic [31:0] DEF_MAX_PACKETS = 32'd100;
    localparam logic [63:0] DEF_WINDOW_NS   = 64'd5000000000;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [16:0] ETH_BYTES       = 17'd14;
    localparam logic [16:0] IPV4_BYTES      = 17'd20;
    localparam logic [16:0] TCP_BYTES       = 17'd20;
    localparam logic [16:0] UDP_BYTES       = 17'd8;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_PACKET = 2'd0,
        FUNC_PORT   = 2'd1,
        FUNC_BLACK  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        RSN_NOT_IPV4  = 3'd0,
        RSN_PASSED    = 3'd1,
        RSN_BLACKLIST = 3'd2,
        RSN_FLOOD     = 3'd3,
        RSN_PORT      = 3'd4,
        RSN_WRITE     = 3'd5
    } reason_t;

    typedef enum logic [0:0] {
        CFG_MAX_PACKETS = 1'b0,
        CFG_WINDOW_NS   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] flood;
        logic [31:0] total;
        logic [63:0] win_start;
        logic        seen_valid;
        logic        blacklisted;
    } entry_t;

    function automatic logic [IDX_W-1:0] onehot_idx(input logic [IP_ENTRIES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < IP_ENTRIES; i++) begin
            if (v[i])
            begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

/* hw/rtl/pibf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pibf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pibf_cell.sv */
// One source table entry: holds its state, matches the key, passes the free chain on.
module pibf_cell
    import pibf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  entry_t      wr_data,
    input  logic [31:0] key,
    input  logic        free_in,
    output logic        free_out,
    output logic        first_free,
    output logic        match,
    output entry_t      entry
);

    logic   valid_reg;
    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    // first free slot claims allocation; later cells see it as taken
    assign first_free = !valid_reg && !free_in;
    assign free_out   = free_in || !valid_reg;
    assign match      = valid_reg && (entry_reg.ip == key);
    assign entry      = entry_reg;

endmodule

/* hw/rtl/per_ip_flood_blacklist_filter_top.sv */
// Top level of the per-source flood limiter, source blacklist and port filter.
//
// Usage: pulse start with an item while busy is low. Every packet (func 0)
// and table write (func 1, 2) gives one result, registered at the end of the
// update step and shown for exactly one cycle with done high; the receiver
// cannot stall, so capture it then. func 3 gives no result. An item passes
// through accept, table lookup and update; a new item can be accepted in the
// cycle its predecessor's result is shown, not earlier. Sources live in a
// row of IP_ENTRIES cells searched in parallel; the lowest free cell is found
// by a chain passed cell to cell. The 65536-entry blocked-port table is a RAM
// cleared after reset by a sweep, one entry per cycle, during which busy
// stays high and no item is accepted; configuration writes are taken at any
// time (cfg_ready is always high) but should only be made while the block
// is idle.
module per_ip_flood_blacklist_filter_top
    import pibf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [31:0] source_ip,
    input  logic [15:0] dest_port,
    input  logic [63:0] now_ns,
    input  logic        block_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic        verdict,
    output logic [2:0]  reason,
    output logic [31:0] window_count,
    output logic [31:0] total_count,
    output logic        tracked
);

    state_t state_reg, state_next;
    logic [PORT_AW:0] clr_cnt_reg;

    logic [31:0] max_packets_reg;
    logic [63:0] window_ns_reg;

    // latched item
    logic [1:0]  func_reg;
    logic [15:0] len_reg;
    logic [15:0] etype_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [15:0] port_reg;
    logic [63:0] now_reg;
    logic        bit_reg;

    // lookup results
    logic             hit_reg, free_reg, pblk_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    entry_t           hit_entry_reg;

    // result registers
    logic        done_reg, verdict_reg, tracked_reg;
    logic [2:0]  reason_reg;
    logic [31:0] flood_out_reg, total_out_reg;

    // cell row
    logic [IP_ENTRIES-1:0] match_v, first_free_v, wr_en_v;
    logic [IP_ENTRIES:0]   free_chain;
    entry_t                cell_entry [IP_ENTRIES];
    entry_t                wr_data;

    logic             port_rd;
    logic             ram_we;
    logic [PORT_AW-1:0] ram_waddr;
    logic             ram_wdata;

    assign free_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < IP_ENTRIES; g++)
        begin : g_cell
            pibf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .wr_en      (wr_en_v[g]),
                .wr_data    (wr_data),
                .key        (src_reg),
                .free_in    (free_chain[g]),
                .free_out   (free_chain[g+1]),
                .first_free (first_free_v[g]),
                .match      (match_v[g]),
                .entry      (cell_entry[g])
            );
        end
    endgenerate

    pibf_ram #(.WIDTH(1), .DEPTH(PORT_DEPTH)) u_port_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (dest_port),
        .rdata (port_rd)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packets_reg <= DEF_MAX_PACKETS;
            window_ns_reg   <= DEF_WINDOW_NS;
        end
        else if (cfg_valid && cfg_ready && !cfg_index[1])
        begin
            case (cfg_idx_t'(cfg_index[0]))
                CFG_MAX_PACKETS: max_packets_reg <= cfg_data[31:0];
                CFG_WINDOW_NS:   window_ns_reg   <= cfg_data;
                default:         max_packets_reg <= max_packets_reg;
            endcase
        end
    end

    // state register and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_cnt_reg == (PORT_AW+1)'(PORT_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (start) state_next = S_LOOK;
            S_LOOK:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg  <= func;
            len_reg   <= frame_length;
            etype_reg <= ether_type;
            ihl_reg   <= ip_header_words;
            proto_reg <= ip_protocol;
            src_reg   <= source_ip;
            port_reg  <= dest_port;
            now_reg   <= now_ns;
            bit_reg   <= block_value;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg       <= |match_v;
            hit_idx_reg   <= onehot_idx(match_v);
            hit_entry_reg <= cell_entry[onehot_idx(match_v)];
            free_reg      <= free_chain[IP_ENTRIES];
            free_idx_reg  <= onehot_idx(first_free_v);
            pblk_reg      <= port_rd;
        end
    end

    // decision logic in the update cycle
    entry_t      cur;
    logic [63:0] delta;
    logic [31:0] flood_inc, total_inc;
    logic [16:0] l4;
    logic        len_ok, l4_bad, is_tcp, is_udp;
    logic        wr_cell;
    logic [IDX_W-1:0] wr_idx;
    logic        r_verdict, r_tracked, r_valid;
    reason_t     r_reason;
    logic [31:0] r_flood, r_total;

    always_comb
    begin
        cur        = hit_reg ? hit_entry_reg : '0;
        cur.ip     = src_reg;
        total_inc  = sat_inc(cur.total);
        flood_inc  = sat_inc(cur.flood);
        delta      = now_reg - cur.win_start;
        len_ok     = ({1'b0, len_reg} >= ETH_BYTES + IPV4_BYTES) &&
                     (etype_reg == ETHERTYPE_IPV4);
        l4         = ETH_BYTES + {11'd0, ihl_reg, 2'b00};
        is_tcp     = (proto_reg == PROTO_TCP);
        is_udp     = (proto_reg == PROTO_UDP);
        l4_bad     = (l4 > {1'b0, len_reg}) ||
                     (is_tcp && (l4 + TCP_BYTES > {1'b0, len_reg})) ||
                     (is_udp && (l4 + UDP_BYTES > {1'b0, len_reg}));
        wr_data    = cur;
        wr_cell    = 1'b0;
        wr_idx     = hit_reg ? hit_idx_reg : free_idx_reg;
        ram_we     = 1'b0;
        ram_waddr  = port_reg;
        ram_wdata  = bit_reg;
        r_valid    = 1'b1;
        r_verdict  = 1'b0;
        r_reason   = RSN_WRITE;
        r_flood    = '0;
        r_total    = '0;
        r_tracked  = 1'b0;

        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[PORT_AW-1:0];
            ram_wdata = 1'b0;
        end

        case (func_t'(func_reg))
            FUNC_PORT:
            begin
                if (state_reg == S_EXEC)
                begin
                    ram_we = 1'b1;
                end
            end
            FUNC_BLACK:
            begin
                if (hit_reg || (bit_reg && free_reg))
                begin
                    wr_cell             = 1'b1;
                    wr_data.blacklisted = bit_reg;
                    r_tracked           = 1'b1;
                end
            end
            FUNC_PACKET:
            begin
                r_reason = RSN_NOT_IPV4;
                if (len_ok)
                begin
                    if (hit_reg && cur.blacklisted)
                    begin
                        r_verdict = 1'b1;
                        r_reason  = RSN_BLACKLIST;
                        r_flood   = cur.flood;
                        r_total   = cur.total;
                        r_tracked = 1'b1;
                    end
                    else
                    begin
                        if (hit_reg || free_reg)
                        begin
                            wr_cell       = 1'b1;
                            r_tracked     = 1'b1;
                            r_total       = total_inc;
                            r_flood       = flood_inc;
                            wr_data.total = total_inc;
                            wr_data.flood = flood_inc;
                            if (!cur.seen_valid)
                            begin
                                wr_data.win_start  = now_reg;
                                wr_data.seen_valid = 1'b1;
                            end
                            else if (delta >= window_ns_reg)
                            begin
                                r_flood           = 32'd1;
                                wr_data.flood     = 32'd1;
                                wr_data.win_start = now_reg;
                            end
                            else if (flood_inc > max_packets_reg)
                            begin
                                wr_data.blacklisted = 1'b1;
                            end
                        end
                        else
                        begin
                            r_flood = 32'd1;
                            r_total = 32'd1;
                        end

                        if (wr_cell && cur.seen_valid && delta < window_ns_reg &&
                            flood_inc > max_packets_reg)
                        begin
                            r_verdict = 1'b1;
                            r_reason  = RSN_FLOOD;
                        end
                        else if (l4_bad)
                        begin
                            r_reason = RSN_NOT_IPV4;
                        end
                        else if ((is_tcp || is_udp) && pblk_reg)
                        begin
                            r_verdict = 1'b1;
                            r_reason  = RSN_PORT;
                        end
                        else
                        begin
                            r_reason = RSN_PASSED;
                        end
                    end
                end
            end
            default:
            begin
                r_valid = 1'b0;
            end
        endcase

        wr_en_v = '0;
        if (state_reg == S_EXEC && wr_cell)
        begin
            wr_en_v[wr_idx] = 1'b1;
        end
    end

    // result strobe: hold for one cycle only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_EXEC) && r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            verdict_reg   <= r_verdict;
            reason_reg    <= r_reason;
            flood_out_reg <= r_flood;
            total_out_reg <= r_total;
            tracked_reg   <= r_tracked;
        end
    end

    assign done         = done_reg;
    assign verdict      = verdict_reg;
    assign reason       = reason_reg;
    assign window_count = flood_out_reg;
    assign total_count  = total_out_reg;
    assign tracked      = tracked_reg;

    // a result follows only an update cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result without update cycle");

    // no item taken during the port table sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("idle during clear sweep");

    // at most one cell written per item
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_en_v))
        else $error("multiple cells written");

endmodule

/* tb/sv/per_ip_flood_blacklist_filter_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the per-source flood limiter and blacklist filter.
//
// Drive header descriptors and table writes through the start/busy command
// port and collect each done strobe. The scoreboard class keeps its own copy
// of the source table, the blocked-port table and both registers. It works
// out the verdict of every transferred item and compares every result with
// the oldest outstanding verdict. The run has several register settings,
// including the extremes. Each setting is written only while nothing is in
// flight.
module per_ip_flood_blacklist_filter_top_test;
    import pibf_pkg::*;

    typedef struct {
        func_t       fn;
        logic [15:0] len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [15:0] port;
        logic [63:0] now;
        logic        bval;
    } hdr_item_t;

    typedef struct {
        logic        verdict;
        reason_t     reason;
        logic [31:0] flood;
        logic [31:0] total;
        logic        tracked;
    } verdict_t;

    // Filter predictor plus a queue of verdicts that are still due.
    class filter_scoreboard;
        logic [31:0] max_pk;
        logic [63:0] win;
        bit          valid[IP_ENTRIES];
        logic [31:0] ip[IP_ENTRIES];
        logic [31:0] flood[IP_ENTRIES];
        logic [31:0] total[IP_ENTRIES];
        logic [63:0] start_ns[IP_ENTRIES];
        bit          seen[IP_ENTRIES];
        bit          black[IP_ENTRIES];
        bit          pblk[PORT_DEPTH];
        verdict_t    pending_q[$];
        int          errors;
        int          checked;
        int          reason_hits[8];

        function new();
            max_pk = DEF_MAX_PACKETS;
            win    = DEF_WINDOW_NS;
            foreach (valid[i]) valid[i] = 0;
            foreach (pblk[i]) pblk[i] = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [63:0] d);
            if (idx == CFG_MAX_PACKETS) max_pk = d[31:0];
            else win = d;
        endfunction

        function int lookup(logic [31:0] a);
            for (int i = 0; i < IP_ENTRIES; i++)
                if (valid[i] && ip[i] == a) return i;
            return -1;
        endfunction

        function int claim(logic [31:0] a);
            for (int i = 0; i < IP_ENTRIES; i++)
            begin
                if (!valid[i])
                begin
                    valid[i] = 1; ip[i] = a; flood[i] = 0; total[i] = 0;
                    start_ns[i] = 0; seen[i] = 0; black[i] = 0;
                    return i;
                end
            end
            return -1;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == COUNT_MAX) ? v : v + 32'd1;
        endfunction

        function void push(logic v, reason_t r, logic [31:0] f, logic [31:0] t, logic tr);
            verdict_t x;
            x.verdict = v; x.reason = r; x.flood = f; x.total = t; x.tracked = tr;
            pending_q.push_back(x);
        endfunction

        // Note a transferred item and queue the verdict it must produce.
        function void note(hdr_item_t it);
            int          e;
            logic [31:0] f, t;
            logic [16:0] l4;
            logic [63:0] dt;
            logic        tr;
            if (it.fn == FUNC_PORT)
            begin
                pblk[it.port] = it.bval;
                push(0, RSN_WRITE, 0, 0, 0);
                return;
            end
            if (it.fn == FUNC_BLACK)
            begin
                e = lookup(it.src);
                if (e < 0 && it.bval) e = claim(it.src);
                if (e >= 0) black[e] = it.bval;
                push(0, RSN_WRITE, 0, 0, e >= 0);
                return;
            end
            if (it.fn != FUNC_PACKET) return;
            if ({1'b0, it.len} < ETH_BYTES + IPV4_BYTES || it.etype != ETHERTYPE_IPV4)
            begin
                push(0, RSN_NOT_IPV4, 0, 0, 0);
                return;
            end
            e = lookup(it.src);
            if (e >= 0 && black[e])
            begin
                push(1, RSN_BLACKLIST, flood[e], total[e], 1);
                return;
            end
            if (e < 0) e = claim(it.src);
            if (e < 0)
            begin
                f = 1; t = 1; tr = 0;
            end
            else
            begin
                tr = 1;
                t = bump(total[e]);
                f = bump(flood[e]);
                total[e] = t;
                flood[e] = f;
                if (seen[e])
                begin
                    dt = it.now - start_ns[e];
                    if (dt < win && f > max_pk)
                    begin
                        black[e] = 1;
                        push(1, RSN_FLOOD, f, t, 1);
                        return;
                    end
                    if (dt >= win)
                    begin
                        f = 1; flood[e] = 1; start_ns[e] = it.now;
                    end
                end
                else
                begin
                    start_ns[e] = it.now; seen[e] = 1;
                end
            end
            l4 = ETH_BYTES + 17'(it.ihl) * 17'd4;
            if (l4 > {1'b0, it.len} ||
                (it.proto == PROTO_TCP && l4 + TCP_BYTES > {1'b0, it.len}) ||
                (it.proto == PROTO_UDP && l4 + UDP_BYTES > {1'b0, it.len}))
                push(0, RSN_NOT_IPV4, f, t, tr);
            else if ((it.proto == PROTO_TCP || it.proto == PROTO_UDP) && pblk[it.port])
                push(1, RSN_PORT, f, t, tr);
            else
                push(0, RSN_PASSED, f, t, tr);
        endfunction

        function void field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Check one strobed result against the oldest pending verdict.
        function void check(verdict_t got);
            verdict_t want;
            if (pending_q.size() == 0)
            begin
                $error("result with no pending item: reason %0d", got.reason);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            reason_hits[want.reason]++;
            field("verdict", want.verdict, got.verdict);
            field("reason", want.reason, got.reason);
            field("window_count", want.flood, got.flood);
            field("total_count", want.total, got.total);
            field("tracked", want.tracked, got.tracked);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [15:0] dest_port;
    logic [63:0] now_ns;
    logic        block_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        done;
    logic        verdict;
    logic [2:0]  reason;
    logic [31:0] window_count;
    logic [31:0] total_count;
    logic        tracked;

    per_ip_flood_blacklist_filter_top u_dut (.*);

    filter_scoreboard sb = new();

    localparam int STALL_LIMIT = 400000;   // covers the port-table clearing sweep
    localparam int POOL_N      = 24;

    logic [31:0] ip_pool[POOL_N];
    logic [15:0] port_pool[8];
    logic [63:0] clock_ns;
    bit          quiet;
    int          sent;
    int          idle_cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Capture every strobed result; the receiver has no way to stall.
    always @(posedge clk)
    begin
        verdict_t r;
        if (rst_n && done)
        begin
            r.verdict = verdict; r.reason = reason_t'(reason);
            r.flood = window_count; r.total = total_count; r.tracked = tracked;
            sb.check(r);
        end
    end

    // Watchdog: end the run when no transfer and no result happen for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive one item and hold it until the block takes it.
    task automatic send(hdr_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        func <= it.fn; frame_length <= it.len; ether_type <= it.etype;
        ip_header_words <= it.ihl; ip_protocol <= it.proto; source_ip <= it.src;
        dest_port <= it.port; now_ns <= it.now; block_value <= it.bval;
        do @(posedge clk); while (busy);
        sb.note(it);
        sent++;
    endtask

    // Drain the pipeline, then write one register.
    task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
        start <= 1'b0;
        wait (sb.pending_q.size() == 0);
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= 2'(idx);
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    function automatic hdr_item_t mk(func_t fn, int len, logic [15:0] et, int ihl,
                                     logic [7:0] pr, logic [31:0] src, logic [15:0] pt,
                                     logic bv);
        hdr_item_t it;
        it.fn = fn; it.len = 16'(len); it.etype = et; it.ihl = 4'(ihl);
        it.proto = pr; it.src = src; it.port = pt; it.bval = bv;
        clock_ns += 64'd10;
        it.now = clock_ns;
        return it;
    endfunction

    function automatic hdr_item_t rand_item();
        hdr_item_t it;
        int        r;
        r = $urandom_range(0, 99);
        it = mk(FUNC_PACKET, $urandom_range(34, 1500), ETHERTYPE_IPV4,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5,
                PROTO_TCP, 0, port_pool[$urandom_range(0, 7)], $urandom_range(0, 1));
        clock_ns += 64'($urandom_range(0, 400));
        it.now = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : clock_ns;
        case ($urandom_range(0, 3))
            0: it.proto = PROTO_UDP;
            1: it.proto = 8'($urandom);
            default: it.proto = PROTO_TCP;
        endcase
        if ($urandom_range(0, 19) == 0) it.src = $urandom;
        else if ($urandom_range(0, 1) == 0) it.src = ip_pool[$urandom_range(0, 3)];
        else it.src = ip_pool[$urandom_range(0, POOL_N - 1)];
        if ($urandom_range(0, 9) == 0) it.port = 16'($urandom);
        if (r < 8)
            it.fn = FUNC_PORT;
        else if (r < 14)
        begin
            it.fn = FUNC_BLACK;
            it.bval = ($urandom_range(0, 9) < 3);
        end
        else if (r < 16)
            it.fn = FUNC_NONE;
        else if (r < 24)
        begin
            // noise: length, ethertype, header words and protocol drawn over their whole range
            it.fn = func_t'(2'd0);
            it.len = 16'($urandom); it.etype = 16'($urandom);
            it.ihl = 4'($urandom); it.proto = 8'($urandom);
            if ($urandom_range(0, 1) == 0) it.etype = ETHERTYPE_IPV4;
        end
        return it;
    endfunction

    initial
    begin
        logic [31:0] max_set[5] = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd7, DEF_MAX_PACKETS};
        logic [63:0] win_set[5] = '{64'd5000, 64'd3000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
                                    DEF_WINDOW_NS};
        logic [31:0] a, b;
        start = 0; func = '0; frame_length = '0; ether_type = '0; ip_header_words = '0;
        ip_protocol = '0; source_ip = '0; dest_port = '0; now_ns = '0; block_value = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        quiet = 0; sent = 0; clock_ns = 64'd1000;
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        foreach (port_pool[i]) port_pool[i] = 16'($urandom);
        port_pool[0] = 16'd0; port_pool[1] = 16'hFFFF;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        a = ip_pool[0]; b = ip_pool[1];
        send(mk(FUNC_PACKET, 0, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 13, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 33, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 100, 16'h86DD, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 34, ETHERTYPE_IPV4, 5, 8'd1, a, 80, 0));
        send(mk(FUNC_PACKET, 54, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 53, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 42, ETHERTYPE_IPV4, 5, PROTO_UDP, a, 80, 0));
        send(mk(FUNC_PACKET, 41, ETHERTYPE_IPV4, 5, PROTO_UDP, a, 80, 0));
        send(mk(FUNC_PACKET, 34, ETHERTYPE_IPV4, 0, PROTO_UDP, a, 80, 0));
        send(mk(FUNC_PACKET, 65535, ETHERTYPE_IPV4, 15, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 1));
        send(mk(FUNC_PACKET, 73, ETHERTYPE_IPV4, 15, 8'hFF, a, 80, 0));
        send(mk(FUNC_PORT, 0, 0, 0, 0, 0, 80, 1));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, PROTO_UDP, a, 80, 0));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, 8'd1, a, 80, 0));
        send(mk(FUNC_PORT, 0, 0, 0, 0, 0, 80, 0));
        send(mk(FUNC_BLACK, 0, 0, 0, 0, b, 0, 0));
        send(mk(FUNC_BLACK, 0, 0, 0, 0, b, 0, 1));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, PROTO_TCP, b, 80, 0));
        send(mk(FUNC_BLACK, 0, 0, 0, 0, a, 0, 1));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));
        send(mk(FUNC_BLACK, 0, 0, 0, 0, a, 0, 0));
        send(mk(FUNC_NONE, 0, 0, 0, 0, a, 0, 0));
        send(mk(FUNC_PACKET, 60, ETHERTYPE_IPV4, 5, PROTO_TCP, a, 80, 0));

        // Random part: one block of traffic per register setting.
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_MAX_PACKETS, {32'd0, max_set[p]});
            write_reg(CFG_WINDOW_NS, win_set[p]);
            quiet = (p == 4);
            for (int n = 0; n < 265; n++) send(rand_item());
        end

        start <= 1'b0;
        wait (sb.pending_q.size() == 0);
        repeat (10) @(posedge clk);
        $display("Sent %0d items over 5 register settings; %0d results checked.",
                 sent, sb.checked);
        $display("Reason hits: not-ipv4 %0d, pass %0d, black %0d, flood %0d, port %0d, write %0d",
                 sb.reason_hits[0], sb.reason_hits[1], sb.reason_hits[2],
                 sb.reason_hits[3], sb.reason_hits[4], sb.reason_hits[5]);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
